// ===== rtl/tdtq_pkg.sv =====
// Package: shared types and constants of the two-domain timeout queue.
package tdtq_pkg;

	localparam int THREAD_W    = 8;
	localparam int AMOUNT_W    = 32;
	localparam int TIME_W      = 64;
	localparam int STEP_W      = 8;
	localparam int MAX_RESULTS = 16;
	localparam int REL_W       = $clog2(MAX_RESULTS + 1);

	// Input command codes.
	typedef enum logic [1:0] {
		CMD_FAST_TICK = 2'd0,
		CMD_SLOW_TICK = 2'd1,
		CMD_SET       = 2'd2,
		CMD_CANCEL    = 2'd3
	} cmd_t;

	// Time unit codes of a set command.
	localparam logic [1:0] UNIT_MS  = 2'd0;
	localparam logic [1:0] UNIT_SEC = 2'd1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PARAM   = 2'd1,
		ST_FULL    = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	// Configuration register indexes.
	localparam logic REG_FAST_STEP = 1'b0;
	localparam logic REG_SLOW_STEP = 1'b1;

	// Configuration write port bundle.
	typedef struct packed {
		logic              we;
		logic              index;
		logic [STEP_W-1:0] data;
	} cfg_t;

	// A classified command as it waits in the queue.
	typedef struct packed {
		cmd_t                cmd;
		logic [THREAD_W-1:0] thread;
		logic [AMOUNT_W-1:0] amount;
		logic                dom;
		logic                bad;
	} item_t;

	// Head of the command queue as the back end sees it.
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DONE,
		B_FLUSH
	} back_state_t;

endpackage

// ===== rtl/tdtq_if.sv =====
// Interfaces: command channel and result channel.
interface tdtq_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  thread_id;
	logic [31:0] timeout_amount;
	logic [1:0]  time_unit;

	modport source (output valid, command, thread_id, timeout_amount, time_unit, input ready);
	modport sink (input valid, command, thread_id, timeout_amount, time_unit, output ready);
endinterface

interface tdtq_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_thread;
	logic [1:0] result_status;
	logic       last_result;

	modport source (output valid, result_thread, result_status, last_result, input ready);
	modport sink (input valid, result_thread, result_status, last_result, output ready);
endinterface

// ===== rtl/tdtq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tdtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tdtq_front.sv =====
// Front end: accepts command beats, classifies them and queues them for the back end.
module tdtq_front import tdtq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tdtq_in_if.sink    in_ch,
	input  logic       pop,
	output head_t      head
);

	item_t       ent_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	item_t       cls;
	logic        push;
	cmd_t        cmd;

	// Classify the incoming beat: domain and parameter check.
	// Ticks take their domain from the command, sets and cancels from the time unit.
	always_comb begin
		cmd        = cmd_t'(in_ch.command);
		cls.cmd    = cmd;
		cls.thread = in_ch.thread_id;
		cls.amount = in_ch.timeout_amount;
		cls.dom    = ((cmd == CMD_FAST_TICK) || (cmd == CMD_SLOW_TICK)) ?
			(cmd == CMD_SLOW_TICK) : (in_ch.time_unit == UNIT_SEC);
		unique case (cmd)
			CMD_SET: begin
				cls.bad = (in_ch.thread_id == '0) || (in_ch.timeout_amount == '1) ||
					((in_ch.time_unit != UNIT_MS) && (in_ch.time_unit != UNIT_SEC));
			end
			CMD_CANCEL: cls.bad = (in_ch.thread_id == '0);
			default:    cls.bad = 1'b0;
		endcase
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign head.valid  = (cnt_q != 2'd0);
	assign head.item   = ent_q[rp_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

endmodule

// ===== rtl/tdtq_back.sv =====
// Back end: counters, timeout table and the sequencer that scans and releases entries.
module tdtq_back import tdtq_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  head_t      head,
	output logic       pop,
	tdtq_out_if.source out_ch
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam int ENT_W = 1 + THREAD_W + TIME_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	back_state_t         state_q, state_d;
	logic [STEP_W-1:0]   fast_step_q, slow_step_q;
	logic [TIME_W-1:0]   fast_time_q, slow_time_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	item_t               op_q;
	logic [CNT_W-1:0]    issue_cnt_q;
	logic                rd_v_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                found_q, match_q, free_q;
	logic [IDX_W-1:0]    best_idx_q, match_idx_q, free_idx_q;
	logic [TIME_W-1:0]   best_dl_q;
	logic [THREAD_W-1:0] best_thr_q;
	logic                pend_q;
	logic [THREAD_W-1:0] pend_thr_q;
	logic [REL_W-1:0]    rel_cnt_q;
	logic                out_valid_q;
	logic [THREAD_W-1:0] out_thr_q;
	status_t             out_st_q;
	logic                out_last_q;

	logic                is_tick;
	logic                out_free;
	logic [TIME_W-1:0]   now;
	logic [ENT_W-1:0]    rd_data;
	logic                rd_dom;
	logic [THREAD_W-1:0] rd_thr;
	logic [TIME_W-1:0]   rd_dl;
	logic                cand;
	logic                last_release;
	logic                scan_start;
	logic                emit;
	logic [THREAD_W-1:0] emit_thr;
	status_t             emit_st;
	logic                emit_last;
	logic                release_en;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic                set_valid;
	logic                clr_valid;
	logic [IDX_W-1:0]    clr_idx;

	assign is_tick  = (op_q.cmd == CMD_FAST_TICK) || (op_q.cmd == CMD_SLOW_TICK);
	assign out_free = !out_valid_q || out_ch.ready;
	assign now      = op_q.dom ? slow_time_q : fast_time_q;
	assign {rd_dom, rd_thr, rd_dl} = rd_data;
	assign cand = rd_v_s1 && valid_q[rd_idx_s1] && (rd_dom == op_q.dom) && (rd_dl <= now);
	assign last_release = (rel_cnt_q + REL_W'(1)) == REL_W'(MAX_RESULTS);

	// Entry store: domain, thread and deadline of each slot.
	tdtq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({op_q.dom, op_q.thread, now + TIME_W'(op_q.amount)}),
		.raddr (issue_cnt_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (head.valid) state_d = B_SCAN;
			B_SCAN: if (rd_v_s1 && (rd_idx_s1 == LAST_IDX)) state_d = B_DONE;
			B_DONE: begin
				if (is_tick) begin
					priority if (pend_q && !out_free) state_d = B_DONE;
					else if (found_q && !last_release) state_d = B_SCAN;
					else if (found_q) state_d = B_FLUSH;
					else state_d = B_IDLE;
				end else if (out_free) begin
					state_d = B_IDLE;
				end
			end
			B_FLUSH: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		pop        = 1'b0;
		emit       = 1'b0;
		emit_thr   = op_q.thread;
		emit_st    = ST_OK;
		emit_last  = 1'b1;
		release_en = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = match_q ? match_idx_q : free_idx_q;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		clr_idx    = best_idx_q;
		scan_start = (state_d == B_SCAN) && (state_q != B_SCAN);
		unique case (state_q)
			B_IDLE: pop = head.valid;
			B_DONE: begin
				if (is_tick) begin
					emit       = pend_q && out_free;
					emit_thr   = pend_thr_q;
					emit_st    = ST_TIMEOUT;
					emit_last  = !found_q;
					release_en = found_q && (!pend_q || out_free);
					clr_valid  = release_en;
				end else begin
					emit = out_free;
					if (op_q.cmd == CMD_SET) begin
						priority if (op_q.bad) emit_st = ST_PARAM;
						else if (match_q || free_q) begin
							emit_st   = ST_OK;
							ram_we    = out_free;
							set_valid = out_free;
						end else emit_st = ST_FULL;
					end else begin
						clr_idx = match_idx_q;
						if (op_q.bad || !match_q) begin
							emit_st = ST_PARAM;
						end else begin
							emit_st   = ST_OK;
							clr_valid = out_free;
						end
					end
				end
			end
			B_FLUSH: begin
				emit      = out_free;
				emit_thr  = pend_thr_q;
				emit_st   = ST_TIMEOUT;
				emit_last = 1'b1;
			end
			default: ;
		endcase
	end

	// Control state, counters, valid bits and scan trackers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			fast_step_q <= STEP_W'(1);
			slow_step_q <= STEP_W'(1);
			fast_time_q <= '0;
			slow_time_q <= '0;
			valid_q     <= '0;
			issue_cnt_q <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			pend_q      <= 1'b0;
			rel_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.we) begin
				if (cfg.index == REG_FAST_STEP) fast_step_q <= cfg.data;
				if (cfg.index == REG_SLOW_STEP) slow_step_q <= cfg.data;
			end
			// Tick commands advance their counter as they are taken.
			if (pop && (head.item.cmd == CMD_FAST_TICK)) begin
				fast_time_q <= fast_time_q + TIME_W'(fast_step_q);
			end
			if (pop && (head.item.cmd == CMD_SLOW_TICK)) begin
				slow_time_q <= slow_time_q + TIME_W'(slow_step_q);
			end
			if (pop) begin
				pend_q    <= 1'b0;
				rel_cnt_q <= '0;
			end
			// A released entry becomes the pending result; the older one leaves.
			if (release_en) begin
				pend_q    <= 1'b1;
				rel_cnt_q <= rel_cnt_q + REL_W'(1);
			end else if (emit && (state_q == B_DONE) && is_tick) begin
				pend_q <= 1'b0;
			end
			if (set_valid) valid_q[ram_waddr] <= 1'b1;
			if (clr_valid) valid_q[clr_idx] <= 1'b0;
			// Read issue and scan pipeline.
			if (scan_start) begin
				issue_cnt_q <= '0;
				rd_v_s1     <= 1'b0;
				found_q     <= 1'b0;
				match_q     <= 1'b0;
				free_q      <= 1'b0;
			end else begin
				rd_v_s1 <= (state_q == B_SCAN) && (issue_cnt_q < CNT_W'(TABLE_SLOTS));
				if ((state_q == B_SCAN) && (issue_cnt_q < CNT_W'(TABLE_SLOTS))) begin
					issue_cnt_q <= issue_cnt_q + CNT_W'(1);
				end
				if (cand && (!found_q || (rd_dl < best_dl_q))) found_q <= 1'b1;
				if (rd_v_s1 && valid_q[rd_idx_s1] && (rd_thr == op_q.thread)) match_q <= 1'b1;
				if (rd_v_s1 && !valid_q[rd_idx_s1]) free_q <= 1'b1;
			end
			// Result register.
			if (emit) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) op_q <= head.item;
		rd_idx_s1 <= issue_cnt_q[IDX_W-1:0];
		if (!scan_start) begin
			if (cand && (!found_q || (rd_dl < best_dl_q))) begin
				best_idx_q <= rd_idx_s1;
				best_dl_q  <= rd_dl;
				best_thr_q <= rd_thr;
			end
			if (rd_v_s1 && valid_q[rd_idx_s1] && (rd_thr == op_q.thread) && !match_q) begin
				match_idx_q <= rd_idx_s1;
			end
			if (rd_v_s1 && !valid_q[rd_idx_s1] && !free_q) free_idx_q <= rd_idx_s1;
		end
		if (release_en) pend_thr_q <= best_thr_q;
		if (emit) begin
			out_thr_q  <= emit_thr;
			out_st_q   <= emit_st;
			out_last_q <= emit_last;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.result_thread = out_thr_q;
	assign out_ch.result_status = out_st_q;
	assign out_ch.last_result   = out_last_q;

endmodule

// ===== rtl/two_domain_timeout_queue.sv =====
// Top level: timeout queue with a millisecond and a second time domain.
//
// Channels: in_ch carries commands (fast tick, slow tick, set, cancel) as
// valid/ready beats; out_ch returns result beats with valid/ready. A set or
// cancel gives one result; a tick gives one result per released thread, the
// last one marked by last_result, or none when nothing is due.
// The cfg_we/cfg_index/cfg_data port writes the two tick step registers.
// Timing: a two-entry command queue decouples the front end from the
// sequencer. Every command is served by a scan of the entry RAM, one slot a
// cycle; a tick repeats the scan for each released thread, plus a final scan
// that finds nothing unless MAX_RESULTS threads were released. The single
// read port of the entry RAM sets this pace.
// Reset clears both counters, all valid bits and sets both steps to one.
// When the receiver stalls, the held result keeps its value; the sequencer
// waits at its next result while the two-entry queue accepts commands until it is full.
module two_domain_timeout_queue import tdtq_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [STEP_W-1:0] cfg_data,
	tdtq_in_if.sink           in_ch,
	tdtq_out_if.source        out_ch
);

	cfg_t  cfg;
	head_t head;
	logic  pop;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Command intake and classification.
	tdtq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.pop    (pop),
		.head   (head)
	);

	// Table sequencer.
	tdtq_back #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

// ===== rtl/tdtq_checker.sv =====
// Checker: port-level assertions on the result channel, bound to the top level.
module tdtq_checker import tdtq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] result_thread,
	input logic [1:0] result_status,
	input logic       last_result
);

	// A stalled result beat stays and holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_thread) &&
		$stable(result_status) && $stable(last_result))
		else $error("result beat changed under stall");

	// Only a tick release may be followed by more results of the same command.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_status != ST_TIMEOUT) |-> last_result)
		else $error("set or cancel result without last mark");

	// A released thread is never thread zero.
	a_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_status == ST_TIMEOUT) |-> (result_thread != 8'd0))
		else $error("thread zero released");

	// Any command that names thread zero is a parameter error.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_thread == 8'd0) |-> (result_status == ST_PARAM))
		else $error("thread zero accepted");

endmodule

bind two_domain_timeout_queue tdtq_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.result_thread (out_ch.result_thread),
	.result_status (out_ch.result_status),
	.last_result   (out_ch.last_result)
);
